[sv/tssf_pkg.sv]
package tssf_pkg;

	localparam int COORD_W = 16;
	localparam int ROW_W   = 6;
	localparam int NUM_W   = COORD_W + ROW_W;
	localparam int Q_W     = COORD_W + 2;
	localparam int CNT_W   = $clog2(NUM_W);

	localparam logic [COORD_W-1:0] PAINT_WHITE = 16'hFFFF;

	typedef struct packed {
		logic               go;
		logic               neg;
		logic [NUM_W-1:0]   num;
		logic [COORD_W-1:0] den;
	} tssf_div_req_t;

	typedef struct packed {
		logic                  done;
		logic signed [Q_W-1:0] q;
	} tssf_div_rsp_t;

endpackage

[sv/triangle_scanline_span_fill.sv]
// Filled-triangle span generator. Pulse start while busy is low to load one
// triangle (three vertices and a paint word); busy stays high until the last
// span has been issued. Each on-screen row from the top to the bottom vertex
// gives one span, shown for exactly one cycle with strobe high; the receiver
// cannot hold spans off, so it must take every strobe. The final span of a
// triangle carries last. Flat triangles and triangles wholly below the screen
// give no span. Both span ends come from one shared divider that yields one
// quotient bit per cycle, so each row runs two divisions in turn, long edge
// then short edge, before its span is issued; a row on a flat half runs only
// the long-edge division.
module triangle_scanline_span_fill #(
	parameter int SCREEN_ROWS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [tssf_pkg::COORD_W-1:0]  ax,
	input  logic [tssf_pkg::COORD_W-1:0]  ay,
	input  logic [tssf_pkg::COORD_W-1:0]  bx,
	input  logic [tssf_pkg::COORD_W-1:0]  by,
	input  logic [tssf_pkg::COORD_W-1:0]  cx,
	input  logic [tssf_pkg::COORD_W-1:0]  cy,
	input  logic [tssf_pkg::COORD_W-1:0]  paint,
	output logic                          strobe,
	output logic [tssf_pkg::ROW_W-1:0]    row,
	output logic [tssf_pkg::COORD_W-1:0]  span_start,
	output logic [tssf_pkg::COORD_W-1:0]  span_end,
	output logic                          ink,
	output logic                          last
);
	import tssf_pkg::*;

	localparam logic [COORD_W-1:0] ROW_MAX = COORD_W'(SCREEN_ROWS - 1);

	typedef enum logic [2:0] {ST_IDLE, ST_CHECK, ST_MUL, ST_DIV, ST_EMIT} state_t;

	state_t              state_q;
	logic [COORD_W-1:0]  x1_q, y1_q, x2_q, y2_q, x3_q, y3_q;
	logic                ink_q;
	logic [ROW_W-1:0]    y_q, ye_q;
	logic                edge_q;
	logic [COORD_W-1:0]  xa_q, xl_q, xs_q;
	logic                go_q, neg_q;
	logic [NUM_W-1:0]    num_q;
	logic [COORD_W-1:0]  den_q;

	logic                strobe_q, last_q, ink_out_q;
	logic [ROW_W-1:0]    row_q;
	logic [COORD_W-1:0]  lo_q, hi_q;

	// sort
	logic [COORD_W-1:0]  s1x, s1y, s2x, s2y, s3x, s3y, t;

	// edge select
	logic [COORD_W-1:0]  sxa, sya, sxb, syb, sden, smag;
	logic                sneg;
	logic [ROW_W-1:0]    sdy;
	logic [COORD_W-1:0]  yend;
	logic signed [Q_W-1:0] xsum;

	tssf_div_req_t req;
	tssf_div_rsp_t rsp;

	always_comb begin
		s1x = ax; s1y = ay; s2x = bx; s2y = by; s3x = cx; s3y = cy;
		t = '0;
		if (s1y > s2y) begin
			t = s1x; s1x = s2x; s2x = t;
			t = s1y; s1y = s2y; s2y = t;
		end
		if (s2y > s3y) begin
			t = s2x; s2x = s3x; s3x = t;
			t = s2y; s2y = s3y; s3y = t;
		end
		if (s1y > s2y) begin
			t = s1x; s1x = s2x; s2x = t;
			t = s1y; s1y = s2y; s2y = t;
		end
	end

	always_comb begin
		if (!edge_q) begin
			sxa = x1_q; sya = y1_q; sxb = x3_q; syb = y3_q;
		end else if ({{(COORD_W-ROW_W){1'b0}}, y_q} <= y2_q) begin
			sxa = x1_q; sya = y1_q; sxb = x2_q; syb = y2_q;
		end else begin
			sxa = x2_q; sya = y2_q; sxb = x3_q; syb = y3_q;
		end
		sden = syb - sya;
		sdy  = y_q - sya[ROW_W-1:0];
		sneg = sxb < sxa;
		smag = sneg ? sxa - sxb : sxb - sxa;
	end

	assign yend = (y3_q < ROW_MAX) ? y3_q : ROW_MAX;
	assign xsum = $signed({2'b00, xa_q}) + rsp.q;

	assign req.go  = go_q;
	assign req.neg = neg_q;
	assign req.num = num_q;
	assign req.den = den_q;

	tssf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			x1_q <= '0; y1_q <= '0; x2_q <= '0; y2_q <= '0; x3_q <= '0; y3_q <= '0;
			ink_q     <= 1'b0;
			y_q       <= '0;
			ye_q      <= '0;
			edge_q    <= 1'b0;
			xa_q      <= '0;
			xl_q      <= '0;
			xs_q      <= '0;
			go_q      <= 1'b0;
			neg_q     <= 1'b0;
			num_q     <= '0;
			den_q     <= '0;
			strobe_q  <= 1'b0;
			last_q    <= 1'b0;
			ink_out_q <= 1'b0;
			row_q     <= '0;
			lo_q      <= '0;
			hi_q      <= '0;
		end else begin
			strobe_q <= 1'b0;
			go_q     <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						x1_q <= s1x; y1_q <= s1y;
						x2_q <= s2x; y2_q <= s2y;
						x3_q <= s3x; y3_q <= s3y;
						ink_q   <= (paint == PAINT_WHITE);
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (y1_q == y3_q || y1_q > yend) begin
						state_q <= ST_IDLE;
					end else begin
						y_q     <= y1_q[ROW_W-1:0];
						ye_q    <= yend[ROW_W-1:0];
						edge_q  <= 1'b0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (sden == '0) begin
						// flat half: short end sits on the upper vertex
						xs_q    <= sxa;
						state_q <= ST_EMIT;
					end else begin
						num_q   <= NUM_W'(smag) * NUM_W'(sdy);
						neg_q   <= sneg;
						den_q   <= sden;
						xa_q    <= sxa;
						go_q    <= 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (rsp.done) begin
						if (!edge_q) begin
							xl_q    <= xsum[COORD_W-1:0];
							edge_q  <= 1'b1;
							state_q <= ST_MUL;
						end else begin
							xs_q    <= xsum[COORD_W-1:0];
							state_q <= ST_EMIT;
						end
					end
				end
				ST_EMIT: begin
					strobe_q  <= 1'b1;
					row_q     <= y_q;
					lo_q      <= (xl_q < xs_q) ? xl_q : xs_q;
					hi_q      <= (xl_q > xs_q) ? xl_q : xs_q;
					ink_out_q <= ink_q;
					last_q    <= (y_q == ye_q);
					if (y_q == ye_q) begin
						state_q <= ST_IDLE;
					end else begin
						y_q     <= y_q + 1'b1;
						edge_q  <= 1'b0;
						state_q <= ST_MUL;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign strobe     = strobe_q;
	assign row        = row_q;
	assign span_start = lo_q;
	assign span_end   = hi_q;
	assign ink        = ink_out_q;
	assign last       = last_q;

endmodule

[sv/tssf_div.sv]
module tssf_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tssf_pkg::tssf_div_req_t req,
	output tssf_pkg::tssf_div_rsp_t rsp
);
	import tssf_pkg::*;

	typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} dstate_t;

	dstate_t                 state_q;
	logic [NUM_W-1:0]        quo_q;
	logic [COORD_W:0]        rem_q;
	logic [COORD_W-1:0]      den_q;
	logic                    neg_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    done_q;
	logic signed [Q_W-1:0]   q_q;

	logic [COORD_W:0]        rem_sh;
	logic                    fits;
	logic signed [Q_W-1:0]   q_mag;

	// one quotient bit per cycle, restoring
	assign rem_sh = {rem_q[COORD_W-1:0], quo_q[NUM_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};
	assign q_mag  = $signed({2'b00, quo_q[COORD_W-1:0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			quo_q   <= '0;
			rem_q   <= '0;
			den_q   <= '0;
			neg_q   <= 1'b0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			q_q     <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (req.go) begin
						quo_q   <= req.num;
						den_q   <= req.den;
						neg_q   <= req.neg;
						rem_q   <= '0;
						cnt_q   <= CNT_W'(NUM_W - 1);
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
					quo_q <= {quo_q[NUM_W-2:0], fits};
					if (cnt_q == '0)
						state_q <= D_FIX;
					else
						cnt_q <= cnt_q - 1'b1;
				end
				D_FIX: begin
					// floor for negative numerators
					if (neg_q)
						q_q <= -q_mag - Q_W'(rem_q != '0);
					else
						q_q <= q_mag;
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.q    = q_q;

endmodule

[sv/tssf_chk.sv]
module tssf_chk #(
	parameter int SCREEN_ROWS = 64
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic [tssf_pkg::COORD_W-1:0]  ax,
	input logic [tssf_pkg::COORD_W-1:0]  ay,
	input logic [tssf_pkg::COORD_W-1:0]  bx,
	input logic [tssf_pkg::COORD_W-1:0]  by,
	input logic [tssf_pkg::COORD_W-1:0]  cx,
	input logic [tssf_pkg::COORD_W-1:0]  cy,
	input logic [tssf_pkg::COORD_W-1:0]  paint,
	input logic                          strobe,
	input logic [tssf_pkg::ROW_W-1:0]    row,
	input logic [tssf_pkg::COORD_W-1:0]  span_start,
	input logic [tssf_pkg::COORD_W-1:0]  span_end,
	input logic                          ink,
	input logic                          last
);
	import tssf_pkg::*;

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> span_start <= span_end)
		else $error("span ends out of order");

	a_row: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> 32'(row) < SCREEN_ROWS)
		else $error("span row off screen");

	a_mid: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("block went idle before the last span");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("still busy after the last span");

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not raise busy");

endmodule

bind triangle_scanline_span_fill tssf_chk #(.SCREEN_ROWS(SCREEN_ROWS)) u_chk (.*);
